FILE: rtl/dfscd_pkg.sv
// Shared types, codes and helpers of the DFS cycle detector and path counter.
`default_nettype none
package dfscd_pkg;

   localparam int VERTEX_WIDTH = 5;
   localparam int ROW_WIDTH    = 32;
   localparam int COUNT_WIDTH  = 32;
   localparam int VC_WIDTH     = 6;

   localparam logic [VC_WIDTH-1:0] VC_RESET = 6'd32;

   localparam logic KIND_COUNT = 1'b0;
   localparam logic KIND_CYCLE = 1'b1;

   typedef struct packed {
      logic [VERTEX_WIDTH-1:0] row_index;
      logic [ROW_WIDTH-1:0]    row_bits;
   } req_type;

   typedef struct packed {
      logic                    kind;
      logic [VERTEX_WIDTH-1:0] vertex;
      logic [COUNT_WIDTH-1:0]  path_count;
      logic                    last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROOT,
      ST_FETCH,
      ST_LATCH,
      ST_SCAN,
      ST_POP,
      ST_ACC_A,
      ST_ACC_B,
      ST_ACC_W,
      ST_CNT_RD,
      ST_CNT_LD,
      ST_CNT_WAIT,
      ST_CYC_LD,
      ST_CYC_WAIT,
      ST_FIN
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_ROOT_SKIP,
      OP_ROOT_PUSH,
      OP_FETCH,
      OP_LATCH,
      OP_SCAN_NEXT,
      OP_PUSH,
      OP_CYCLE,
      OP_EDGE_DONE,
      OP_POP_ROOT,
      OP_POP,
      OP_ACC_A,
      OP_ACC_B,
      OP_ACC_W,
      OP_CNT_RD,
      OP_CNT_LD,
      OP_CNT_STEP,
      OP_CYC_LD,
      OP_CYC_STEP,
      OP_FIN_LD
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic trigger;
      logic root_end;
      logic root_seen;
      logic scan_end;
      logic row_hit;
      logic mark_open;
      logic mark_done;
      logic top_zero;
      logic ret_pop;
      logic k_at_top;
      logic k_at_last;
      logic rsp_taken;
   } status_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/dfscd_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dfscd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: rtl/dfscd_ctrl.sv
// Sequencer of the DFS cycle detector: loads rows, walks the search, streams results.
`default_nettype none
module dfscd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire dfscd_pkg::status_type status,
   output dfscd_pkg::cmd_type        cmd
);
   dfscd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfscd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfscd_pkg::ST_IDLE: begin
            if (req_valid && status.trigger) state_in = dfscd_pkg::ST_INIT;
         end
         dfscd_pkg::ST_INIT:  state_in = dfscd_pkg::ST_ROOT;
         dfscd_pkg::ST_ROOT: begin
            priority if (status.root_end) state_in = dfscd_pkg::ST_CNT_RD;
            else if (!status.root_seen)   state_in = dfscd_pkg::ST_FETCH;
            else                          state_in = dfscd_pkg::ST_ROOT;
         end
         dfscd_pkg::ST_FETCH: state_in = dfscd_pkg::ST_LATCH;
         dfscd_pkg::ST_LATCH: state_in = dfscd_pkg::ST_SCAN;
         dfscd_pkg::ST_SCAN: begin
            priority if (status.scan_end) state_in = dfscd_pkg::ST_POP;
            else if (!status.row_hit)     state_in = dfscd_pkg::ST_SCAN;
            else if (status.mark_done)    state_in = dfscd_pkg::ST_ACC_A;
            else if (status.mark_open)    state_in = dfscd_pkg::ST_CYC_LD;
            else                          state_in = dfscd_pkg::ST_FETCH;
         end
         dfscd_pkg::ST_POP: begin
            state_in = status.top_zero ? dfscd_pkg::ST_ROOT : dfscd_pkg::ST_ACC_A;
         end
         dfscd_pkg::ST_ACC_A: state_in = dfscd_pkg::ST_ACC_B;
         dfscd_pkg::ST_ACC_B: state_in = dfscd_pkg::ST_ACC_W;
         dfscd_pkg::ST_ACC_W: begin
            state_in = status.ret_pop ? dfscd_pkg::ST_FETCH : dfscd_pkg::ST_SCAN;
         end
         dfscd_pkg::ST_CNT_RD: state_in = dfscd_pkg::ST_CNT_LD;
         dfscd_pkg::ST_CNT_LD: state_in = dfscd_pkg::ST_CNT_WAIT;
         dfscd_pkg::ST_CNT_WAIT: begin
            if (status.rsp_taken) begin
               state_in = status.k_at_last ? dfscd_pkg::ST_IDLE : dfscd_pkg::ST_CNT_RD;
            end
         end
         dfscd_pkg::ST_CYC_LD: state_in = dfscd_pkg::ST_CYC_WAIT;
         dfscd_pkg::ST_CYC_WAIT: begin
            if (status.rsp_taken) begin
               state_in = status.k_at_top ? dfscd_pkg::ST_FIN : dfscd_pkg::ST_CYC_LD;
            end
         end
         dfscd_pkg::ST_FIN: begin
            // first pass loads the closing vertex, then wait for its transfer
            if (status.rsp_taken) state_in = dfscd_pkg::ST_IDLE;
         end
         default: state_in = dfscd_pkg::ST_IDLE;
      endcase
   end

   logic fin_loaded_ff, fin_loaded_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_loaded_ff <= 1'b0;
      end else begin
         fin_loaded_ff <= fin_loaded_in;
      end
   end

   assign fin_loaded_in = (state_ff == dfscd_pkg::ST_FIN) && !status.rsp_taken;

   always_comb begin
      cmd.op    = dfscd_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         dfscd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = dfscd_pkg::OP_LOAD;
         end
         dfscd_pkg::ST_INIT: cmd.op = dfscd_pkg::OP_INIT;
         dfscd_pkg::ST_ROOT: begin
            priority if (status.root_end) cmd.op = dfscd_pkg::OP_NONE;
            else if (status.root_seen)    cmd.op = dfscd_pkg::OP_ROOT_SKIP;
            else                          cmd.op = dfscd_pkg::OP_ROOT_PUSH;
         end
         dfscd_pkg::ST_FETCH: cmd.op = dfscd_pkg::OP_FETCH;
         dfscd_pkg::ST_LATCH: cmd.op = dfscd_pkg::OP_LATCH;
         dfscd_pkg::ST_SCAN: begin
            priority if (status.scan_end) cmd.op = dfscd_pkg::OP_NONE;
            else if (!status.row_hit)     cmd.op = dfscd_pkg::OP_SCAN_NEXT;
            else if (status.mark_done)    cmd.op = dfscd_pkg::OP_EDGE_DONE;
            else if (status.mark_open)    cmd.op = dfscd_pkg::OP_CYCLE;
            else                          cmd.op = dfscd_pkg::OP_PUSH;
         end
         dfscd_pkg::ST_POP: begin
            cmd.op = status.top_zero ? dfscd_pkg::OP_POP_ROOT : dfscd_pkg::OP_POP;
         end
         dfscd_pkg::ST_ACC_A:  cmd.op = dfscd_pkg::OP_ACC_A;
         dfscd_pkg::ST_ACC_B:  cmd.op = dfscd_pkg::OP_ACC_B;
         dfscd_pkg::ST_ACC_W:  cmd.op = dfscd_pkg::OP_ACC_W;
         dfscd_pkg::ST_CNT_RD: cmd.op = dfscd_pkg::OP_CNT_RD;
         dfscd_pkg::ST_CNT_LD: cmd.op = dfscd_pkg::OP_CNT_LD;
         dfscd_pkg::ST_CNT_WAIT: begin
            if (status.rsp_taken && !status.k_at_last) cmd.op = dfscd_pkg::OP_CNT_STEP;
         end
         dfscd_pkg::ST_CYC_LD: cmd.op = dfscd_pkg::OP_CYC_LD;
         dfscd_pkg::ST_CYC_WAIT: begin
            if (status.rsp_taken && !status.k_at_top) cmd.op = dfscd_pkg::OP_CYC_STEP;
         end
         dfscd_pkg::ST_FIN: begin
            if (!fin_loaded_ff) cmd.op = dfscd_pkg::OP_FIN_LD;
         end
         default: cmd.op = dfscd_pkg::OP_NONE;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/dfscd_datapath.sv
// Datapath of the DFS cycle detector: row store, marks, stack, counts, result register.
`default_nettype none
module dfscd_datapath #(
   parameter int MAX_VERTICES = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire dfscd_pkg::cmd_type                     cmd,
   output dfscd_pkg::status_type                       status,
   input  wire dfscd_pkg::req_type                     req_payload,
   input  wire logic                                   csr_write_enable,
   input  wire logic [dfscd_pkg::VC_WIDTH-1:0]         csr_write_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output dfscd_pkg::rsp_type                          rsp_payload
);
   localparam int NV = (MAX_VERTICES < dfscd_pkg::ROW_WIDTH) ? MAX_VERTICES
                                                             : dfscd_pkg::ROW_WIDTH;
   localparam int IW = $clog2(NV);
   localparam int CW = IW + 1;
   localparam int VCW = dfscd_pkg::VC_WIDTH;
   localparam int PW  = dfscd_pkg::COUNT_WIDTH;

   // configuration and active vertex count
   logic [VCW-1:0] vc_ff, vc_in;
   logic [CW-1:0]  n;

   always_comb begin
      priority if (vc_ff == '0)         n = CW'(1);
      else if (vc_ff > VCW'(NV))        n = CW'(NV);
      else                              n = CW'(vc_ff);
   end

   // search state
   logic [NV-1:0] open_ff, open_in;
   logic [NV-1:0] done_ff, done_in;
   logic [NV-1:0] ptv_ff, ptv_in;
   logic [CW-1:0] root_ff, root_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] top_ff, top_in;
   logic [CW-1:0] u_ff, u_in;
   logic [NV-1:0] row_ff, row_in;
   logic [IW-1:0] stk_v_ff [NV];
   logic [IW-1:0] stk_v_in [NV];
   logic [CW-1:0] stk_n_ff [NV];
   logic [CW-1:0] stk_n_in [NV];
   logic [IW-1:0] vdep_ff [NV];
   logic [IW-1:0] vdep_in [NV];
   logic [IW-1:0] src_ff, src_in;
   logic [IW-1:0] dst_ff, dst_in;
   logic          ret_ff, ret_in;
   logic [PW-1:0] a1_ff, a1_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] start_ff, start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   dfscd_pkg::rsp_type rsp_ff, rsp_in;

   // memories
   logic [NV-1:0] adj_rdata;
   logic [PW-1:0] pt_rdata;
   logic          pt_rd_en;
   logic [IW-1:0] pt_rd_addr;
   logic [IW-1:0] pt_mask_idx;
   logic [PW-1:0] pt_val;
   logic          row_ok;

   assign row_ok = {1'b0, req_payload.row_index} < VCW'(NV);

   dfscd_ram #(.WIDTH(NV), .DEPTH(NV)) adj_ram (
      .clock   (clock),
      .wr_en   ((cmd.op == dfscd_pkg::OP_LOAD) && row_ok),
      .wr_addr (req_payload.row_index[IW-1:0]),
      .wr_data (req_payload.row_bits[NV-1:0]),
      .rd_en   (cmd.op == dfscd_pkg::OP_FETCH),
      .rd_addr (cur_ff),
      .rd_data (adj_rdata)
   );

   dfscd_ram #(.WIDTH(PW), .DEPTH(NV)) pt_ram (
      .clock   (clock),
      .wr_en   (cmd.op == dfscd_pkg::OP_ACC_W),
      .wr_addr (dst_ff),
      .wr_data (dfscd_pkg::sat_add(pt_val, a1_ff)),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rdata)
   );

   always_comb begin
      pt_rd_en   = (cmd.op == dfscd_pkg::OP_ACC_A) || (cmd.op == dfscd_pkg::OP_ACC_B) ||
                   (cmd.op == dfscd_pkg::OP_CNT_RD);
      pt_rd_addr = k_ff;
      if (cmd.op == dfscd_pkg::OP_ACC_A) pt_rd_addr = src_ff;
      if (cmd.op == dfscd_pkg::OP_ACC_B) pt_rd_addr = dst_ff;
      pt_mask_idx = k_ff;
      if (cmd.op == dfscd_pkg::OP_ACC_B) pt_mask_idx = src_ff;
      if (cmd.op == dfscd_pkg::OP_ACC_W) pt_mask_idx = dst_ff;
   end

   // counts never written in this search read as zero
   assign pt_val = ptv_ff[pt_mask_idx] ? pt_rdata : '0;

   // single stack read port
   logic [IW-1:0] stk_idx;
   logic [IW-1:0] uv;

   always_comb begin
      stk_idx = top_ff;
      if (cmd.op == dfscd_pkg::OP_POP)    stk_idx = top_ff - IW'(1);
      if (cmd.op == dfscd_pkg::OP_CYC_LD) stk_idx = k_ff;
   end

   assign uv = u_ff[IW-1:0];

   always_comb begin
      status.trigger   = {1'b0, req_payload.row_index} == (VCW'(n) - VCW'(1));
      status.root_end  = root_ff >= n;
      status.root_seen = open_ff[root_ff[IW-1:0]] | done_ff[root_ff[IW-1:0]];
      status.scan_end  = u_ff >= n;
      status.row_hit   = row_ff[uv];
      status.mark_open = open_ff[uv];
      status.mark_done = done_ff[uv];
      status.top_zero  = top_ff == '0;
      status.ret_pop   = ret_ff;
      status.k_at_top  = k_ff == top_ff;
      status.k_at_last = CW'(k_ff) == (n - CW'(1));
      status.rsp_taken = rsp_valid_ff && rsp_ready;
   end

   always_comb begin
      vc_in        = vc_ff;
      open_in      = open_ff;
      done_in      = done_ff;
      ptv_in       = ptv_ff;
      root_in      = root_ff;
      cur_in       = cur_ff;
      top_in       = top_ff;
      u_in         = u_ff;
      row_in       = row_ff;
      stk_v_in     = stk_v_ff;
      stk_n_in     = stk_n_ff;
      vdep_in      = vdep_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      ret_in       = ret_ff;
      a1_in        = a1_ff;
      k_in         = k_ff;
      start_in     = start_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_write_enable) vc_in = csr_write_data;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (cmd.op)
         dfscd_pkg::OP_INIT: begin
            open_in = '0;
            done_in = '0;
            ptv_in  = '0;
            root_in = '0;
            k_in    = '0;
         end
         dfscd_pkg::OP_ROOT_SKIP: root_in = root_ff + CW'(1);
         dfscd_pkg::OP_ROOT_PUSH: begin
            open_in[root_ff[IW-1:0]] = 1'b1;
            cur_in                   = root_ff[IW-1:0];
            top_in                   = '0;
            stk_v_in[0]              = root_ff[IW-1:0];
            stk_n_in[0]              = '0;
            vdep_in[root_ff[IW-1:0]] = '0;
         end
         dfscd_pkg::OP_LATCH: begin
            row_in = adj_rdata;
            u_in   = stk_n_ff[stk_idx];
         end
         dfscd_pkg::OP_SCAN_NEXT: u_in = u_ff + CW'(1);
         dfscd_pkg::OP_PUSH: begin
            stk_n_in[top_ff]           = u_ff + CW'(1);
            open_in[uv]                = 1'b1;
            top_in                     = top_ff + IW'(1);
            stk_v_in[top_ff + IW'(1)]  = uv;
            stk_n_in[top_ff + IW'(1)]  = '0;
            vdep_in[uv]                = top_ff + IW'(1);
            cur_in                     = uv;
         end
         dfscd_pkg::OP_CYCLE: begin
            // emit from the start's stack slot up to the top
            start_in = uv;
            k_in     = vdep_ff[uv];
         end
         dfscd_pkg::OP_EDGE_DONE: begin
            stk_n_in[top_ff] = u_ff + CW'(1);
            u_in             = u_ff + CW'(1);
            src_in           = uv;
            dst_in           = cur_ff;
            ret_in           = 1'b0;
         end
         dfscd_pkg::OP_POP_ROOT: begin
            done_in[cur_ff] = 1'b1;
            open_in[cur_ff] = 1'b0;
            root_in         = root_ff + CW'(1);
         end
         dfscd_pkg::OP_POP: begin
            done_in[cur_ff] = 1'b1;
            open_in[cur_ff] = 1'b0;
            src_in          = cur_ff;
            dst_in          = stk_v_ff[stk_idx];
            cur_in          = stk_v_ff[stk_idx];
            top_in          = top_ff - IW'(1);
            ret_in          = 1'b1;
         end
         dfscd_pkg::OP_ACC_B: a1_in = dfscd_pkg::sat_add(pt_val, PW'(1));
         dfscd_pkg::OP_ACC_W: ptv_in[dst_ff] = 1'b1;
         dfscd_pkg::OP_CNT_LD: begin
            rsp_in.kind       = dfscd_pkg::KIND_COUNT;
            rsp_in.vertex     = dfscd_pkg::VERTEX_WIDTH'(k_ff);
            rsp_in.path_count = pt_val;
            rsp_in.last       = status.k_at_last;
            rsp_valid_in      = 1'b1;
         end
         dfscd_pkg::OP_CNT_STEP: k_in = k_ff + IW'(1);
         dfscd_pkg::OP_CYC_LD: begin
            rsp_in.kind       = dfscd_pkg::KIND_CYCLE;
            rsp_in.vertex     = dfscd_pkg::VERTEX_WIDTH'(stk_v_ff[stk_idx]);
            rsp_in.path_count = '0;
            rsp_in.last       = 1'b0;
            rsp_valid_in      = 1'b1;
         end
         dfscd_pkg::OP_CYC_STEP: k_in = k_ff + IW'(1);
         dfscd_pkg::OP_FIN_LD: begin
            rsp_in.kind       = dfscd_pkg::KIND_CYCLE;
            rsp_in.vertex     = dfscd_pkg::VERTEX_WIDTH'(start_ff);
            rsp_in.path_count = '0;
            rsp_in.last       = 1'b1;
            rsp_valid_in      = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= dfscd_pkg::VC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         vc_ff        <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      open_ff  <= open_in;
      done_ff  <= done_in;
      ptv_ff   <= ptv_in;
      root_ff  <= root_in;
      cur_ff   <= cur_in;
      top_ff   <= top_in;
      u_ff     <= u_in;
      row_ff   <= row_in;
      stk_v_ff <= stk_v_in;
      stk_n_ff <= stk_n_in;
      vdep_ff  <= vdep_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      ret_ff   <= ret_in;
      a1_ff    <= a1_in;
      k_ff     <= k_in;
      start_ff <= start_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

FILE: rtl/dfs_cycle_detect_path_count_top.sv
// Top level of the DFS cycle detector and path counter.
// Adjacency rows are taken one per transfer, one per cycle while idle. The
// row whose index is vertex_count-1 starts a depth-first search from roots
// in ascending order; the neighbor scan tests one adjacency bit per cycle,
// a row is fetched on each descent and each return, and per edge to a
// finished vertex or non-root pop the source and destination counts are
// read in turn and the source count plus one is added to the destination
// count (one registered count read port). Results then go out when the
// output side is ready; each is loaded into the result register and held
// until transferred before the next. That is n path counts when the graph
// is acyclic, or the cycle from its start to its end followed by the start
// again. No new row is taken until a search's last result is transferred.
`default_nettype none
module dfs_cycle_detect_path_count_top #(
   parameter int MAX_VERTICES = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire dfscd_pkg::req_type             req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output dfscd_pkg::rsp_type                  rsp_payload,
   input  wire logic                           csr_write_enable,
   input  wire logic [dfscd_pkg::VC_WIDTH-1:0] csr_write_data
);
   dfscd_pkg::cmd_type    cmd;
   dfscd_pkg::status_type status;

   dfscd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dfscd_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );
endmodule
`default_nettype wire
